### rtl/qph_pkg.sv
// shared widths and constants for the quadratic probe hash insert block
`default_nettype none
package qph_pkg;

	localparam int KEY_W      = 32;
	localparam int CFG_W      = 11;
	localparam int SLOT_OUT_W = 10;
	localparam int CNT_W      = 32;

	localparam logic [CFG_W-1:0] SIZE_RESET = 11'd1021;

endpackage
`default_nettype wire

### rtl/qph_ram.sv
// generic single write port ram with registered read
`default_nettype none
module qph_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(DEPTH)-1:0] waddr,
	input  wire  [WIDTH-1:0]         wdata,
	input  wire  [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

### rtl/qph_modsub.sv
// shared compare and subtract unit: one reduction step modulo m
`default_nettype none
module qph_modsub #(
	parameter int W = 11
) (
	input  wire  [W-1:0] a,
	input  wire  [W-1:0] m,
	output logic [W-1:0] r
);

	always_comb begin
		if (a >= m) begin
			r = a - m;
		end else begin
			r = a;
		end
	end

endmodule
`default_nettype wire

### rtl/quadratic_probe_hash_insert_core.sv
// sequence: remainder steps over the key bits, then per probe an index, a check and a
//   step update (the last probe skips it), then the result is posted once the output is free
// throughput: one insert at a time, set by the single compare-subtract unit and the
//   one-read-per-probe occupancy ram; in_ready is low while an insert is in flight
// reset: arst_n clears control state and the collision count and loads size 1021;
//   then every occupancy ram entry is swept clear with in_ready low
`default_nettype none
module quadratic_probe_hash_insert_core #(
	parameter int TABLE_DEPTH = 1024
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_valid,
	output logic                            cfg_ready,
	input  wire  [qph_pkg::CFG_W-1:0]       cfg_data,
	input  wire                             in_valid,
	output logic                            in_ready,
	input  wire  [qph_pkg::KEY_W-1:0]       key,
	output logic                            out_valid,
	input  wire                             out_ready,
	output logic [qph_pkg::SLOT_OUT_W-1:0]  slot_index,
	output logic                            collided,
	output logic                            table_full,
	output logic [qph_pkg::CNT_W-1:0]       collision_total
);

	import qph_pkg::*;

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int UW = IW + 1;
	localparam int DIV_CW = $clog2(KEY_W);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_PIDX  = 3'd3;
	localparam logic [2:0] ST_PCHK  = 3'd4;
	localparam logic [2:0] ST_PD    = 3'd5;
	localparam logic [2:0] ST_FIN   = 3'd6;

	logic [2:0]        state_q;
	logic [IW-1:0]     clr_q;
	logic [CFG_W-1:0]  table_size_q;
	logic [UW-1:0]     size_q;
	logic [KEY_W-1:0]  key_q;
	logic [DIV_CW-1:0] div_cnt_q;
	logic [IW-1:0]     rem_q;
	logic [IW-1:0]     sq_q;
	logic [IW-1:0]     d_q;
	logic [UW-1:0]     i_q;
	logic [IW-1:0]     idx_q;
	logic              hit_q;
	logic              found_q;
	logic [CNT_W-1:0]  cnt_q;

	logic              out_valid_q;
	logic [IW-1:0]     slot_q;
	logic              coll_q;
	logic              full_q;
	logic [CNT_W-1:0]  total_q;

	logic [31:0]       ts_ext;
	logic [31:0]       eff_size;
	logic [UW-1:0]     size_d;
	logic [UW-1:0]     unit_a;
	logic [UW-1:0]     unit_r;
	logic [UW-1:0]     i_next;
	logic              occ_rdata;
	logic              ram_we;
	logic [IW-1:0]     ram_waddr;
	logic              ram_wdata;
	logic              accept;
	logic              post;
	logic [31:0]       slot_ext;

	// size 0 reads as 1, sizes past the depth saturate
	always_comb begin
		ts_ext = 32'(table_size_q);
		if (ts_ext == 32'd0) begin
			eff_size = 32'd1;
		end else if (ts_ext > 32'(TABLE_DEPTH)) begin
			eff_size = 32'(TABLE_DEPTH);
		end else begin
			eff_size = ts_ext;
		end
		size_d = eff_size[UW-1:0];
	end

	// operand select for the shared unit
	always_comb begin
		case (state_q)
			ST_DIV:  unit_a = {rem_q, key_q[KEY_W-1]};
			ST_PIDX: unit_a = UW'(rem_q) + UW'(sq_q);
			ST_PCHK: unit_a = UW'(sq_q) + UW'(d_q);
			ST_PD:   unit_a = UW'(d_q) + UW'(2);
			default: unit_a = '0;
		endcase
	end

	qph_modsub #(
		.W(UW)
	) u_unit (
		.a(unit_a),
		.m(size_q),
		.r(unit_r)
	);

	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = 1'b0;
		end else begin
			ram_we    = (state_q == ST_PCHK) && !occ_rdata;
			ram_waddr = idx_q;
			ram_wdata = 1'b1;
		end
	end

	qph_ram #(
		.WIDTH(1),
		.DEPTH(TABLE_DEPTH)
	) u_occ (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(unit_r[IW-1:0]),
		.rdata(occ_rdata)
	);

	assign i_next = i_q + UW'(1);
	assign accept = in_valid && in_ready;
	assign post   = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			table_size_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + IW'(1);
					if (clr_q == IW'(TABLE_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_cnt_q == DIV_CW'(KEY_W - 1)) begin
						state_q <= ST_PIDX;
					end
				end
				ST_PIDX: state_q <= ST_PCHK;
				ST_PCHK: begin
					if (occ_rdata && i_q == '0) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					if (!occ_rdata || i_next == size_q) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_PD;
					end
				end
				ST_PD:   state_q <= ST_PIDX;
				ST_FIN: begin
					if (post) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers of the insert in flight
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				key_q     <= key;
				size_q    <= size_d;
				div_cnt_q <= '0;
				rem_q     <= '0;
				sq_q      <= '0;
				d_q       <= (size_d == UW'(1)) ? IW'(0) : IW'(1);
				i_q       <= '0;
				hit_q     <= 1'b0;
				found_q   <= 1'b0;
			end
			ST_DIV: begin
				key_q     <= {key_q[KEY_W-2:0], 1'b0};
				div_cnt_q <= div_cnt_q + DIV_CW'(1);
				rem_q     <= unit_r[IW-1:0];
			end
			ST_PIDX: idx_q <= unit_r[IW-1:0];
			ST_PCHK: begin
				if (!occ_rdata) begin
					found_q <= 1'b1;
				end else begin
					if (i_q == '0) begin
						hit_q <= 1'b1;
					end
					sq_q <= unit_r[IW-1:0];
					i_q  <= i_next;
				end
			end
			ST_PD:   d_q <= unit_r[IW-1:0];
			default: ;
		endcase
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (post) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (post) begin
			slot_q  <= found_q ? idx_q : '0;
			coll_q  <= hit_q;
			full_q  <= !found_q;
			total_q <= cnt_q;
		end
	end

	assign slot_ext        = 32'(slot_q);
	assign cfg_ready       = 1'b1;
	assign in_ready        = (state_q == ST_IDLE);
	assign out_valid       = out_valid_q;
	assign slot_index      = slot_ext[SLOT_OUT_W-1:0];
	assign collided        = coll_q;
	assign table_full      = full_q;
	assign collision_total = total_q;

endmodule
`default_nettype wire

### rtl/qph_checker.sv
// port-level checks for the quadratic probe hash insert core, with its bind
`default_nettype none
module qph_checker (
	input wire                            clk,
	input wire                            arst_n,
	input wire                            in_valid,
	input wire                            in_ready,
	input wire                            out_valid,
	input wire                            out_ready,
	input wire [qph_pkg::SLOT_OUT_W-1:0]  slot_index,
	input wire                            collided,
	input wire                            table_full,
	input wire [qph_pkg::CNT_W-1:0]       collision_total
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(slot_index)
		&& $stable(collided) && $stable(table_full) && $stable(collision_total))
		else $error("result word changed while stalled");

	// a full table reports slot zero
	a_full_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && table_full |-> slot_index == '0)
		else $error("table full with nonzero slot");

	// one insert at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an insert is in flight");

	// occupancy sweep keeps the input closed right after reset
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> !in_ready && !out_valid)
		else $error("input open during clearing sweep");

endmodule

bind quadratic_probe_hash_insert_core qph_checker u_qph_checker (.*);
`default_nettype wire

### test/qph_insert_checker.sv
// checker for the quadratic probe hash insert core: shadow table, expected reports, compare
`timescale 1ns / 1ps
`default_nettype none
module qph_insert_checker #(
	parameter int DEPTH = 1024
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_valid,
	input  wire                             cfg_ready,
	input  wire  [qph_pkg::CFG_W-1:0]       cfg_data,
	input  wire                             in_valid,
	input  wire                             in_ready,
	input  wire  [qph_pkg::KEY_W-1:0]       key,
	input  wire                             out_valid,
	input  wire                             out_ready,
	input  wire  [qph_pkg::SLOT_OUT_W-1:0]  slot_index,
	input  wire                             collided,
	input  wire                             table_full,
	input  wire  [qph_pkg::CNT_W-1:0]       collision_total,
	output int                              fail_count,
	output int                              outstanding
);

	import qph_pkg::*;

	typedef struct packed {
		logic [SLOT_OUT_W-1:0] slot;
		logic                  hit_first;
		logic                  full;
		logic [CNT_W-1:0]      total;
	} insert_report_t;

	logic [CFG_W-1:0] size_reg;
	logic             slot_used [0:DEPTH-1];
	logic [CNT_W-1:0] collisions;
	insert_report_t   reports_due [$];
	insert_report_t   want;
	int               bad;

	// walks the probe sequence on the shadow table and marks the chosen slot used
	function automatic insert_report_t place_key(input logic [KEY_W-1:0] k);
		longint unsigned span;
		longint unsigned base;
		longint unsigned probe;
		longint unsigned idx;
		bit found;
		insert_report_t r;
		span = (size_reg == '0) ? 1 : ((size_reg > DEPTH) ? DEPTH : size_reg);
		base = k % span;
		found = 1'b0;
		idx = 0;
		r = '0;
		for (probe = 0; probe < span && !found; probe++) begin
			idx = (base + (probe * probe) % span) % span;
			if (!slot_used[idx])
				found = 1'b1;
			else if (probe == 0)
				r.hit_first = 1'b1;
		end
		// a first-slot hit counts even when the insert fails
		if (r.hit_first)
			collisions = collisions + 1'b1;
		if (found) begin
			slot_used[idx] = 1'b1;
			r.slot = idx[SLOT_OUT_W-1:0];
		end
		r.full = !found;
		r.total = collisions;
		return r;
	endfunction

	function automatic int field_bad(input string name, input longint unsigned exp_v,
			input longint unsigned got_v);
		if (exp_v == got_v)
			return 0;
		$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, got_v);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_reg = SIZE_RESET;
			for (int n = 0; n < DEPTH; n++)
				slot_used[n] = 1'b0;
			collisions = '0;
			reports_due.delete();
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			bad = 0;
			if (out_valid && out_ready) begin
				if (reports_due.size() == 0) begin
					$display("%0t: unexpected result word, expected none actual slot %0d",
						$time, slot_index);
					bad = 1;
				end else begin
					want = reports_due.pop_front();
					bad += field_bad("slot_index", want.slot, slot_index);
					bad += field_bad("collided", want.hit_first, collided);
					bad += field_bad("table_full", want.full, table_full);
					bad += field_bad("collision_total", want.total, collision_total);
				end
			end
			if (cfg_valid && cfg_ready)
				size_reg = cfg_data;
			if (in_valid && in_ready)
				reports_due.insert(reports_due.size(), place_key(key));
			fail_count <= fail_count + bad;
			outstanding <= reports_due.size();
		end
	end

endmodule
`default_nettype wire

### test/quadratic_probe_hash_insert_core_test.sv
// testbench top for the quadratic probe hash insert core: stimulus, flow control and verdict
`timescale 1ns / 1ps
`default_nettype none
module quadratic_probe_hash_insert_core_test;

	import qph_pkg::*;

	localparam int DEPTH = 1024;
	localparam int KEYS_PER_PHASE = 36;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_W-1:0]      cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [KEY_W-1:0]      key;
	logic                  out_valid;
	logic                  out_ready;
	logic [SLOT_OUT_W-1:0] slot_index;
	logic                  collided;
	logic                  table_full;
	logic [CNT_W-1:0]      collision_total;
	int                    fail_count;
	int                    outstanding;
	bit                    calm_tail;

	// sizes of the random phases; the last one runs without idling
	int unsigned phase_size [12] = '{3, 1021, 16, 1, 64, 2047, 7, 1024, 0, 31, 128, 997};

	quadratic_probe_hash_insert_core #(
		.TABLE_DEPTH(DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.key(key),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.slot_index(slot_index),
		.collided(collided),
		.table_full(table_full),
		.collision_total(collision_total)
	);

	qph_insert_checker #(
		.DEPTH(DEPTH)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.key(key),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.slot_index(slot_index),
		.collided(collided),
		.table_full(table_full),
		.collision_total(collision_total),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#60_000_000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic int idle_gap();
		if (calm_tail || $urandom_range(0, 2) != 0)
			return 0;
		return $urandom_range(1, 11);
	endfunction

	// mix of wide keys, keys near the occupied low slots, and keys aliasing by the size
	function automatic logic [KEY_W-1:0] pick_key(input int unsigned span);
		case ($urandom_range(0, 2))
			0: return $urandom;
			1: return $urandom_range(0, 2 * span);
			default: return $urandom_range(0, 1000) * span + $urandom_range(0, 3);
		endcase
	endfunction

	// valid stays high into the next word unless a gap is asked for
	task automatic insert_key(input logic [KEY_W-1:0] k, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		key <= k;
		do @(posedge clk); while (!in_ready);
	endtask

	// size changes only once every insert has reported back
	task automatic resize(input logic [CFG_W-1:0] value);
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		out_ready <= 1'b0;
		@(posedge clk);
		forever begin
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 40)) @(posedge clk);
			if (!calm_tail && $urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
		end
	end

	initial begin
		int unsigned span;
		calm_tail = 1'b0;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		key <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset size, extremes of the key, repeated keys
		insert_key(32'd0, 0);
		insert_key(32'hFFFF_FFFF, 0);
		insert_key(32'd1021, 0);
		insert_key(32'd0, 0);
		insert_key(32'hAAAA_AAAA, 0);
		insert_key(32'h5555_5555, 0);
		// size four: quadratic walk from slot 0 only reaches slots 0 and 1
		resize(11'd4);
		insert_key(32'd1, 0);
		insert_key(32'd0, 0);
		insert_key(32'd2, 0);
		insert_key(32'd3, 0);
		insert_key(32'd5, 0);
		// zero size acts as one slot
		resize(11'd0);
		insert_key(32'h1234_5678, 0);
		// top of the register saturates to the depth
		resize(11'd2047);
		insert_key(32'hFFFF_FFFF, 0);
		insert_key(32'd1023, 0);
		insert_key(32'd2047, 0);
		insert_key(32'd1024, 0);
		resize(11'd1);
		insert_key(32'd7, 0);

		foreach (phase_size[p]) begin
			if (p == $size(phase_size) - 1)
				calm_tail = 1'b1;
			resize(phase_size[p][CFG_W-1:0]);
			span = (phase_size[p] == 0) ? 1 : ((phase_size[p] > DEPTH) ? DEPTH : phase_size[p]);
			repeat (KEYS_PER_PHASE) insert_key(pick_key(span), idle_gap());
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
`default_nettype wire

### files.f
rtl/qph_pkg.sv
rtl/qph_ram.sv
rtl/qph_modsub.sv
rtl/quadratic_probe_hash_insert_core.sv
rtl/qph_checker.sv
test/qph_insert_checker.sv
test/quadratic_probe_hash_insert_core_test.sv
